// ===== src/s2d_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; imported by every module of the block.
package s2d_pkg;

  localparam int ValueW  = 16;
  localparam int DigitsN = 5;
  localparam int BcdW    = 4 * DigitsN;
  localparam int CharW   = 7;
  localparam int TdataW  = 8;

  localparam logic [CharW-1:0] ChMinus = 7'd45;
  localparam logic [CharW-1:0] ChZero  = 7'd48;

  // Conversion result handed from the converter to the emitter
  typedef struct packed {
    logic            done;
    logic            neg;
    logic [BcdW-1:0] bcd;
  } s2d_bcd_t;

endpackage

// ===== src/s2d_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on s2d_pkg.
module s2d_dabble import s2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  output logic              busy_o,
  output s2d_bcd_t          res_o
);

  localparam logic [3:0] LastBit = 4'(ValueW - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic              neg_q, neg_d;
  logic [BcdW-1:0]   bcd_adj;

  // Add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < DigitsN; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = value_i[ValueW-1];
      // magnitude of the most negative value wraps to itself, read unsigned
      mag_d  = value_i[ValueW-1] ? (~value_i + 1'b1) : value_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
      mag_d = {mag_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == LastBit) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign busy_o    = busy_q;
  assign res_o.done = done_q;
  assign res_o.neg  = neg_q;
  assign res_o.bcd  = bcd_q;

endmodule

// ===== src/s2d_emit.sv =====
// Character emitter: drops leading zero digits, sends sign and digits one word
// at a time through an output register. Depends on s2d_pkg.
module s2d_emit import s2d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  s2d_bcd_t         res_i,
  output logic             busy_o,
  output logic             tvalid_o,
  input  logic             tready_i,
  output logic [CharW-1:0] char_o,
  output logic             tlast_o
);

  typedef enum logic [1:0] {EIdle, ESkip, EEmit} state_e;

  localparam logic [2:0] DigitsAll = 3'(DigitsN);

  state_e           state_q;
  logic             neg_q;
  logic [BcdW-1:0]  dig_q;
  logic [2:0]       rem_q;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             slot_free;
  logic             emit_fire;
  logic [3:0]       top_dig;

  assign slot_free = !valid_q || tready_i;
  assign emit_fire = (state_q == EEmit) && slot_free;
  assign top_dig   = dig_q[BcdW-1 -: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EIdle;
      valid_q <= 1'b0;
      neg_q   <= 1'b0;
      rem_q   <= '0;
      dig_q   <= '0;
      char_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      // load a new word, or drop the one the sink just took
      if (emit_fire) begin
        valid_q <= 1'b1;
      end else if (tready_i) begin
        valid_q <= 1'b0;
      end
      unique case (state_q)
        EIdle: begin
          if (res_i.done) begin
            dig_q   <= res_i.bcd;
            neg_q   <= res_i.neg;
            rem_q   <= DigitsAll;
            state_q <= ESkip;
          end
        end
        ESkip: begin
          // drop leading zeros, keep at least one digit
          if (top_dig == 4'd0 && rem_q != 3'd1) begin
            dig_q <= {dig_q[BcdW-5:0], 4'd0};
            rem_q <= rem_q - 3'd1;
          end else begin
            state_q <= EEmit;
          end
        end
        EEmit: begin
          if (slot_free) begin
            if (neg_q) begin
              char_q <= ChMinus;
              last_q <= 1'b0;
              neg_q  <= 1'b0;
            end else begin
              char_q <= ChZero + {3'd0, top_dig};
              last_q <= (rem_q == 3'd1);
              dig_q  <= {dig_q[BcdW-5:0], 4'd0};
              rem_q  <= rem_q - 3'd1;
              if (rem_q == 3'd1) begin
                state_q <= EIdle;
              end
            end
          end
        end
        default: state_q <= EIdle;
      endcase
    end
  end

  assign busy_o   = (state_q != EIdle);
  assign tvalid_o = valid_q;
  assign char_o   = char_q;
  assign tlast_o  = last_q;

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// Signed 16-bit value to decimal ASCII text, one character per output word.
// After an input is accepted, the value passes the 16-step bit-serial BCD conversion
// and the leading-zero skip; characters then follow one per cycle while the sink is ready.
// A new value is accepted only once the converter and emitter are both idle, so
// the conversion of a value does not overlap the emission of the previous one.
// Reset (rst_ni low, asynchronous) empties the converter, emitter and output.
module signed_int_to_decimal_ascii import s2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [ValueW-1:0] s_axis_tdata_i,  // [15:0] value (signed)
  // output stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o,  // [6:0] character, [7] zero
  output logic              m_axis_tlast_o   // last character of the value
);

  logic             conv_busy;
  logic             emit_busy;
  s2d_bcd_t         conv_res;
  logic             in_take;
  logic [CharW-1:0] out_char;

  // Take a new word only when the converter and emitter are both idle; the
  // output register may still hold the previous value's final character.
  assign s_axis_tready_o = !conv_busy && !conv_res.done && !emit_busy;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Shift the magnitude into a BCD register, one bit per cycle
  s2d_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_take),
    .value_i (s_axis_tdata_i),
    .busy_o  (conv_busy),
    .res_o   (conv_res)
  );

  // Skip leading zeros, then send sign and digits, most significant first
  s2d_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_i    (conv_res),
    .busy_o   (emit_busy),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .char_o   (out_char),
    .tlast_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(TdataW - CharW){1'b0}}, out_char};

  // A final character is always a digit, never the sign
  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> out_char != ChMinus)
    else $error("sign character flagged as last");

  // An accepted word starts the converter
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> conv_busy)
    else $error("converter did not start after accept");

  // The emitter is idle whenever a conversion result is handed over
  a_handoff_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_res.done |-> !emit_busy)
    else $error("conversion finished while emitter busy");

endmodule
